>>> hdl/hsv_pkg.sv
// Shared types and constants for the RGB to HSV converter.
package hsv_pkg;

    localparam int CH_W       = 8;
    localparam int HUE_W      = 15;
    localparam int NUM_W      = 20;
    localparam int SAT_NUM_W  = 16;
    localparam int Q_W        = 12;
    localparam int DIV_STAGES = Q_W;

    localparam logic [HUE_W-1:0] HUE_SECTOR = HUE_W'(3840);
    localparam logic [HUE_W-1:0] HUE_GREEN  = HUE_W'(2 * HUE_SECTOR);
    localparam logic [HUE_W-1:0] HUE_BLUE   = HUE_W'(4 * HUE_SECTOR);
    localparam logic [HUE_W-1:0] HUE_FULL   = HUE_W'(23040);

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // Per-pixel information that rides alongside the divider.
    typedef struct packed {
        logic [CH_W-1:0] value;
        logic            neg;
        t_sector         sector;
        logic            undef;
    } t_side;

endpackage

>>> hdl/hsv_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes side by side.
module hsv_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [hsv_pkg::NUM_W-1:0] i_num_h,
    input  logic [hsv_pkg::CH_W-1:0]  i_den_h,
    input  logic [hsv_pkg::NUM_W-1:0] i_num_s,
    input  logic [hsv_pkg::CH_W-1:0]  i_den_s,
    input  hsv_pkg::t_side            i_side,
    output logic                      o_valid,
    output logic [hsv_pkg::Q_W-1:0]   o_quo_h,
    output logic [hsv_pkg::Q_W-1:0]   o_quo_s,
    output hsv_pkg::t_side            o_side
);
    import hsv_pkg::*;

    logic             r_valid [DIV_STAGES];
    logic [NUM_W-1:0] r_rem_h [DIV_STAGES];
    logic [NUM_W-1:0] r_rem_s [DIV_STAGES];
    logic [CH_W-1:0]  r_den_h [DIV_STAGES];
    logic [CH_W-1:0]  r_den_s [DIV_STAGES];
    logic [Q_W-1:0]   r_q_h   [DIV_STAGES];
    logic [Q_W-1:0]   r_q_s   [DIV_STAGES];
    t_side            r_side  [DIV_STAGES];

    // Both numerators are below 4096 times their divisor, so twelve steps suffice.
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        localparam int SH = Q_W - 1 - k;

        logic             v_in;
        logic [NUM_W-1:0] rh_in;
        logic [NUM_W-1:0] rs_in;
        logic [CH_W-1:0]  dh_in;
        logic [CH_W-1:0]  ds_in;
        logic [Q_W-1:0]   qh_in;
        logic [Q_W-1:0]   qs_in;
        t_side            sd_in;
        logic [NUM_W-1:0] dh_sh;
        logic [NUM_W-1:0] ds_sh;
        logic             ge_h;
        logic             ge_s;
        logic [NUM_W-1:0] n_rem_h;
        logic [NUM_W-1:0] n_rem_s;
        logic [Q_W-1:0]   n_q_h;
        logic [Q_W-1:0]   n_q_s;

        if (k == 0) begin : g_first
            assign v_in  = i_valid;
            assign rh_in = i_num_h;
            assign rs_in = i_num_s;
            assign dh_in = i_den_h;
            assign ds_in = i_den_s;
            assign qh_in = '0;
            assign qs_in = '0;
            assign sd_in = i_side;
        end else begin : g_next
            assign v_in  = r_valid[k-1];
            assign rh_in = r_rem_h[k-1];
            assign rs_in = r_rem_s[k-1];
            assign dh_in = r_den_h[k-1];
            assign ds_in = r_den_s[k-1];
            assign qh_in = r_q_h[k-1];
            assign qs_in = r_q_s[k-1];
            assign sd_in = r_side[k-1];
        end

        assign dh_sh   = NUM_W'(dh_in) << SH;
        assign ds_sh   = NUM_W'(ds_in) << SH;
        assign ge_h    = (rh_in >= dh_sh);
        assign ge_s    = (rs_in >= ds_sh);
        assign n_rem_h = ge_h ? (rh_in - dh_sh) : rh_in;
        assign n_rem_s = ge_s ? (rs_in - ds_sh) : rs_in;
        assign n_q_h   = qh_in | (Q_W'(ge_h) << SH);
        assign n_q_s   = qs_in | (Q_W'(ge_s) << SH);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= v_in;
            end
            r_rem_h[k] <= n_rem_h;
            r_rem_s[k] <= n_rem_s;
            r_den_h[k] <= dh_in;
            r_den_s[k] <= ds_in;
            r_q_h[k]   <= n_q_h;
            r_q_s[k]   <= n_q_s;
            r_side[k]  <= sd_in;
        end
    end

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_quo_h = r_q_h[DIV_STAGES-1];
    assign o_quo_s = r_q_s[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

endmodule

>>> hdl/rgb_to_hsv_converter_core.sv
// Top level of the pipelined RGB to HSV pixel converter.
//
// This block converts one 8-bit RGB pixel per clock cycle into hue (1/64 degree,
// 0 to 23039), saturation (0 to 255), value and a flag for pixels whose hue is
// undefined because all three channels are equal. A pixel transfer happens at a
// rising edge where start is high and busy is low; busy is always low, so a new
// pixel may be offered in every cycle. Each result appears on the o_ ports for
// exactly one cycle, marked by o_valid, and results leave in the order pixels
// arrived. The receiver cannot stall the block and must take every result in
// the cycle it is shown. The pipeline is one stage that finds the largest and
// smallest channel, one that forms the scaled numerators, the twelve-stage
// restoring divider that forms both the hue and saturation quotients one bit
// per stage, and one output register.
module rgb_to_hsv_converter_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [hsv_pkg::CH_W-1:0]  i_red,
    input  logic [hsv_pkg::CH_W-1:0]  i_green,
    input  logic [hsv_pkg::CH_W-1:0]  i_blue,
    output logic                      o_valid,
    output logic [hsv_pkg::HUE_W-1:0] o_hue,
    output logic [hsv_pkg::CH_W-1:0]  o_saturation,
    output logic [hsv_pkg::CH_W-1:0]  o_value,
    output logic                      o_hue_undefined
);
    import hsv_pkg::*;

    // The pipeline never holds, so the block is always ready for a transfer.
    assign busy = 1'b0;

    logic accept;
    assign accept = start & ~busy;

    // Stage 1: find the largest and smallest channel and the signed channel
    // difference that drives the hue. Ties go to red, then green, then blue.
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] mn;
    t_sector         sector;
    logic [CH_W-1:0] dif_a;
    logic [CH_W-1:0] dif_b;

    always_comb begin
        mx = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx)  mx = i_blue;
        mn = i_red;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn)  mn = i_blue;

        if (i_red == mx) begin
            sector = SEC_RED;
            dif_a  = i_green;
            dif_b  = i_blue;
        end else if (i_green == mx) begin
            sector = SEC_GREEN;
            dif_a  = i_blue;
            dif_b  = i_red;
        end else begin
            sector = SEC_BLUE;
            dif_a  = i_red;
            dif_b  = i_green;
        end
    end

    logic            r_s1_valid;
    logic [CH_W-1:0] r_s1_delta;
    logic [CH_W-1:0] r_s1_absdif;
    t_side           r_s1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
        r_s1_delta         <= mx - mn;
        r_s1_absdif        <= (dif_a < dif_b) ? (dif_b - dif_a) : (dif_a - dif_b);
        r_s1_side.value    <= mx;
        r_s1_side.neg      <= (dif_a < dif_b);
        r_s1_side.sector   <= sector;
        r_s1_side.undef    <= (mx == mn);
    end

    // Stage 2: scale the numerators. 3840 is 4096 - 256 and 255 is 256 - 1, so
    // both products are a shift and a subtract.
    logic             r_s2_valid;
    logic [NUM_W-1:0] r_s2_num_h;
    logic [NUM_W-1:0] r_s2_num_s;
    logic [CH_W-1:0]  r_s2_delta;
    t_side            r_s2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_num_h <= (NUM_W'(r_s1_absdif) << 12) - (NUM_W'(r_s1_absdif) << 8);
        r_s2_num_s <= NUM_W'((SAT_NUM_W'(r_s1_delta) << 8) - SAT_NUM_W'(r_s1_delta));
        r_s2_delta <= r_s1_delta;
        r_s2_side  <= r_s1_side;
    end

    // Stages 3 to 14: the hue quotient divides by delta, the saturation
    // quotient by the largest channel. Grey pixels divide by zero here, and
    // their quotients are discarded at the output.
    logic           div_valid;
    logic [Q_W-1:0] quo_h;
    logic [Q_W-1:0] quo_s;
    t_side          div_side;

    hsv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_valid),
        .i_num_h (r_s2_num_h),
        .i_den_h (r_s2_delta),
        .i_num_s (r_s2_num_s),
        .i_den_s (r_s2_side.value),
        .i_side  (r_s2_side),
        .o_valid (div_valid),
        .o_quo_h (quo_h),
        .o_quo_s (quo_s),
        .o_side  (div_side)
    );

    // Final stage: add the sector base and wrap a negative red hue into range.
    // Truncation toward zero means a negative offset is minus the quotient.
    logic [HUE_W-1:0] base;
    logic [HUE_W-1:0] n_hue;

    always_comb begin
        case (div_side.sector)
            SEC_GREEN: base = HUE_GREEN;
            SEC_BLUE:  base = HUE_BLUE;
            default:   base = '0;
        endcase

        if (div_side.undef) begin
            n_hue = '0;
        end else if (!div_side.neg) begin
            n_hue = base + HUE_W'(quo_h);
        end else if (div_side.sector == SEC_RED) begin
            n_hue = (quo_h == '0) ? '0 : (HUE_FULL - HUE_W'(quo_h));
        end else begin
            n_hue = base - HUE_W'(quo_h);
        end
    end

    logic             r_out_valid;
    logic [HUE_W-1:0] r_hue;
    logic [CH_W-1:0]  r_sat;
    logic [CH_W-1:0]  r_value;
    logic             r_undef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= div_valid;
        end
        r_hue   <= n_hue;
        r_sat   <= div_side.undef ? '0 : quo_s[CH_W-1:0];
        r_value <= div_side.value;
        r_undef <= div_side.undef;
    end

    assign o_valid         = r_out_valid;
    assign o_hue           = r_hue;
    assign o_saturation    = r_sat;
    assign o_value         = r_value;
    assign o_hue_undefined = r_undef;

    // The hue must stay below one full turn.
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue < HUE_FULL))
        else $error("hue out of range");

    // A pixel with undefined hue reports zero hue and zero saturation.
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hue_undefined) |-> (o_hue == '0 && o_saturation == '0))
        else $error("undefined hue with nonzero hue or saturation");

    // A colored pixel has delta of at least one, so saturation cannot be zero.
    a_sat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hue_undefined) |-> (o_saturation != '0 && o_value != '0))
        else $error("colored pixel with zero saturation or value");

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the RGB to HSV pixel converter core.
module tb_top;
    import hsv_pkg::*;

    // Hue is measured in 1/64 degree: one sixth of a turn is 3840 and a full turn 23040.
    localparam int SIXTH_TURN     = 3840;
    localparam int FULL_TURN      = 23040;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int RANDOM_PIXELS  = 1840;
    localparam int BURST_PIXELS   = 60;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  value;
        logic             hue_undefined;
    } t_hsv;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [CH_W-1:0]   i_red;
    logic [CH_W-1:0]   i_green;
    logic [CH_W-1:0]   i_blue;
    logic              o_valid;
    logic [HUE_W-1:0]  o_hue;
    logic [CH_W-1:0]   o_saturation;
    logic [CH_W-1:0]   o_value;
    logic              o_hue_undefined;

    // Predicted HSV results for accepted pixels, oldest first.
    t_hsv pending_hsv[$];
    int   error_count  = 0;
    int   stall_cycles = 0;
    // When clear, pixels are offered back to back with no gaps.
    bit   idle_enable  = 1'b0;

    always #5 i_clk = ~i_clk;

    rgb_to_hsv_converter_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .o_valid         (o_valid),
        .o_hue           (o_hue),
        .o_saturation    (o_saturation),
        .o_value         (o_value),
        .o_hue_undefined (o_hue_undefined)
    );

    // Integer HSV conversion. The dominant channel is picked with ties going to
    // red first, then green, so blue only wins when it is strictly largest.
    function automatic t_hsv predict_hsv(input logic [CH_W-1:0] r, g, b);
        int      red_i;
        int      green_i;
        int      blue_i;
        int      max_i;
        int      min_i;
        int      delta;
        int      hue_i;
        t_sector dominant;
        t_hsv    pix;
        red_i    = r;
        green_i  = g;
        blue_i   = b;
        max_i    = red_i;
        dominant = SEC_RED;
        if (green_i > max_i) begin
            max_i    = green_i;
            dominant = SEC_GREEN;
        end
        if (blue_i > max_i) begin
            max_i    = blue_i;
            dominant = SEC_BLUE;
        end
        min_i = red_i;
        if (green_i < min_i) min_i = green_i;
        if (blue_i < min_i) min_i = blue_i;
        delta     = max_i - min_i;
        pix.value = CH_W'(max_i);
        if (delta == 0) begin
            // Black or grey: hue has no meaning and is reported as zero.
            pix.hue           = '0;
            pix.saturation    = '0;
            pix.hue_undefined = 1'b1;
        end else begin
            pix.saturation = CH_W'((255 * delta) / max_i);
            // Division of signed ints truncates toward zero.
            case (dominant)
                SEC_RED:   hue_i = (SIXTH_TURN * (green_i - blue_i)) / delta;
                SEC_GREEN: hue_i = 2 * SIXTH_TURN + (SIXTH_TURN * (blue_i - red_i)) / delta;
                default:   hue_i = 4 * SIXTH_TURN + (SIXTH_TURN * (red_i - green_i)) / delta;
            endcase
            if (hue_i < 0) hue_i += FULL_TURN;
            pix.hue           = HUE_W'(hue_i);
            pix.hue_undefined = 1'b0;
        end
        return pix;
    endfunction

    // Every pixel transfer is predicted from the pins at the same edge that the
    // block samples them, so the check does not depend on the latency.
    always @(posedge i_clk) begin
        t_hsv want;
        if (i_rst_n === 1'b1) begin
            if (start && busy === 1'b0) begin
                pending_hsv.push_back(predict_hsv(i_red, i_green, i_blue));
            end
            if (o_valid === 1'b1) begin
                if (pending_hsv.size() == 0) begin
                    $error("result transfer with no pixel pending");
                    error_count++;
                end else begin
                    want = pending_hsv.pop_front();
                    if (o_hue !== want.hue) begin
                        $error("hue: expected %0d, actual %0d", want.hue, o_hue);
                        error_count++;
                    end
                    if (o_saturation !== want.saturation) begin
                        $error("saturation: expected %0d, actual %0d",
                               want.saturation, o_saturation);
                        error_count++;
                    end
                    if (o_value !== want.value) begin
                        $error("value: expected %0d, actual %0d", want.value, o_value);
                        error_count++;
                    end
                    if (o_hue_undefined !== want.hue_undefined) begin
                        $error("hue_undefined: expected %0b, actual %0b",
                               want.hue_undefined, o_hue_undefined);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: any transfer in either direction counts as progress.
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offers one pixel after an optional random gap and returns at the edge
    // where the transfer takes place. Start stays high into the next call when
    // that call draws no gap.
    task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
        int gap;
        gap = idle_enable ? $urandom_range(0, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start   <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Equal channels, including both ends of the range.
    task automatic test_grey_levels();
        idle_enable = 1'b0;
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1, 8'd1, 8'd1);
    endtask

    // Primaries and secondaries; the secondaries exercise the tie order.
    task automatic test_primary_colors();
        idle_enable = 1'b1;
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd90, 8'd90, 8'd20);
        send_pixel(8'd20, 8'd90, 8'd90);
    endtask

    // Red dominant with blue above green gives a negative sum that wraps.
    task automatic test_hue_wraparound();
        idle_enable = 1'b0;
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd0, 8'd254);
        send_pixel(8'd255, 8'd0, 8'd128);
        send_pixel(8'd200, 8'd10, 8'd199);
    endtask

    // Smallest deltas and smallest maxima, where rounding matters most.
    task automatic test_small_delta();
        idle_enable = 1'b1;
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd2, 8'd1, 8'd1);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd254, 8'd255, 8'd254);
        send_pixel(8'd254, 8'd254, 8'd255);
        send_pixel(8'd0, 8'd1, 8'd1);
        send_pixel(8'd3, 8'd2, 8'd1);
    endtask

    // Draws one channel level biased toward the interesting corners of the
    // range: the ends, near grey around a base, and very dark pixels.
    function automatic logic [CH_W-1:0] draw_channel(input int kind, input int base);
        int level;
        case (kind)
            2:       level = ($urandom_range(0, 1) != 0) ? 255 : 0;
            3:       level = base + $urandom_range(0, 4) - 2;
            4:       level = $urandom_range(0, 3);
            default: level = $urandom_range(0, 255);
        endcase
        if (level < 0) level = 0;
        if (level > 255) level = 255;
        return CH_W'(level);
    endfunction

    task automatic test_random_pixels(input int count);
        int               kind;
        int               base;
        logic [CH_W-1:0]  ch [3];
        for (int n = 0; n < count; n++) begin
            // Idling comes and goes in stretches of forty pixels.
            if (n % 40 == 0) idle_enable = ($urandom_range(0, 2) != 0);
            kind = $urandom_range(0, 9);
            base = $urandom_range(0, 255);
            if (kind >= 5) kind = 0;
            for (int c = 0; c < 3; c++) ch[c] = draw_channel(kind, base);
            // Grey pixels and two-way ties get a share of their own.
            case ($urandom_range(0, 7))
                0:       begin ch[1] = ch[0]; ch[2] = ch[0]; end
                1:       ch[1] = ch[0];
                2:       ch[2] = ch[1];
                3:       ch[2] = ch[0];
                default: ;
            endcase
            send_pixel(ch[0], ch[1], ch[2]);
        end
    endtask

    // A long unbroken stream at one pixel per cycle.
    task automatic test_back_to_back(input int count);
        idle_enable = 1'b0;
        for (int n = 0; n < count; n++) begin
            send_pixel(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_red   = '0;
        i_green = '0;
        i_blue  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_grey_levels();
        test_primary_colors();
        test_hue_wraparound();
        test_small_delta();
        test_back_to_back(BURST_PIXELS);
        test_random_pixels(RANDOM_PIXELS);

        @(negedge i_clk);
        start <= 1'b0;
        // A missing result leaves the queue non-empty and the watchdog fires.
        while (pending_hsv.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
